// File: hw/rtl/cflk_pkg.sv
// candle flicker generator: shared types, constants and the control program
// no dependencies; used by cflk_rng, cflk_seq and candle_flicker_generator
package cflk_pkg;

  localparam int unsigned CH_W   = 3;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned IDX_W  = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_VARIABILITY = 2'd0;
  localparam logic [IDX_W-1:0] REG_AGILITY     = 2'd1;
  localparam logic [IDX_W-1:0] REG_CALMNESS    = 2'd2;
  localparam logic [IDX_W-1:0] REG_BASELINE    = 2'd3;

  localparam logic [7:0] RST_VARIABILITY = 8'd5;
  localparam logic [6:0] RST_AGILITY     = 7'd2;
  localparam logic [2:0] RST_CALMNESS    = 3'd2;
  localparam logic [7:0] RST_BASELINE    = 8'd30;

  localparam logic [7:0] GUST_LIMIT = 8'd220;
  localparam logic [7:0] LEVEL_MAX  = 8'd255;

  typedef logic [2:0] step_t;

  // program steps
  localparam step_t S_GUST_TEST  = 3'd0;
  localparam step_t S_GUST_ODDS  = 3'd1;
  localparam step_t S_GUST_SET   = 3'd2;
  localparam step_t S_SETTLE     = 3'd3;
  localparam step_t S_KNOCK_TEST = 3'd4;
  localparam step_t S_KNOCK_SET  = 3'd5;
  localparam step_t S_FILTER     = 3'd6;

  typedef enum logic [1:0] {
    CMP_NONE,
    CMP_LT_VAR,
    CMP_GT_LIMIT,
    CMP_LT_CALM
  } cmp_sel_t;

  typedef struct packed {
    logic     draw;        // advance the generator this step
    cmp_sel_t cmp;         // which test feeds the branch
    logic     jump;        // branch to target when the test fails
    step_t    target;
    logic     load_wind;   // wind takes the draw
    logic     settle;      // wind decays, flame grows
    logic     load_flame;  // flame takes the draw
    logic     fin;         // filter, write back, hand out the result
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '{draw: 1'b0, cmp: CMP_NONE, jump: 1'b0, target: S_FILTER,
          load_wind: 1'b0, settle: 1'b0, load_flame: 1'b0, fin: 1'b0};
    unique case (s)
      S_GUST_TEST: begin
        w.draw = 1'b1; w.cmp = CMP_LT_VAR; w.jump = 1'b1; w.target = S_SETTLE;
      end
      S_GUST_ODDS: begin
        w.draw = 1'b1; w.cmp = CMP_GT_LIMIT; w.jump = 1'b1; w.target = S_SETTLE;
      end
      S_GUST_SET: begin
        w.draw = 1'b1; w.load_wind = 1'b1;
      end
      S_SETTLE: begin
        w.settle = 1'b1;
      end
      S_KNOCK_TEST: begin
        w.draw = 1'b1; w.cmp = CMP_LT_CALM; w.jump = 1'b1; w.target = S_FILTER;
      end
      S_KNOCK_SET: begin
        w.draw = 1'b1; w.load_flame = 1'b1;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/cflk_rng.sv
// candle flicker generator: shared 8-bit pseudo-random generator
// counter plus three mixing bytes, wrapping arithmetic; uses cflk_pkg
module cflk_rng import cflk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              draw,
  output logic [DATA_W-1:0] value
);

  logic [DATA_W-1:0] counter, mix_a, mix_b, mix_c;
  logic [DATA_W-1:0] counter_next, mix_a_next, mix_b_next, mix_c_next;

  always_comb begin
    counter_next = counter + 8'd1;
    mix_a_next   = mix_a ^ mix_c ^ counter_next;
    mix_b_next   = mix_b + mix_a_next;
    mix_c_next   = (mix_c + (mix_b_next >> 1)) ^ mix_a_next;
  end

  // value is what this draw returns
  assign value = mix_c_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      mix_a   <= '0;
      mix_b   <= '0;
      mix_c   <= '0;
    end else if (draw) begin
      counter <= counter_next;
      mix_a   <= mix_a_next;
      mix_b   <= mix_b_next;
      mix_c   <= mix_c_next;
    end
  end

endmodule

// File: hw/rtl/cflk_seq.sv
// candle flicker generator: step counter and control program sequencer
// reads the program table from cflk_pkg
module cflk_seq import cflk_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  step_t start_step,
  input  logic  cond,
  input  logic  out_free,
  output ctrl_t ctrl,
  output logic  busy
);

  step_t step;

  assign ctrl = ucode(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= S_GUST_TEST;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        step <= start_step;
      end
    end else if (ctrl.fin) begin
      if (out_free) begin
        busy <= 1'b0;
      end
    end else if (ctrl.jump && !cond) begin
      step <= ctrl.target;
    end else begin
      step <= step + 3'd1;
    end
  end

endmodule

// File: hw/rtl/candle_flicker_generator.sv
// candle flicker generator: one flame update per request, result registered
// an accepted request walks the program steps (gust test, gust odds, gust set, settle, knock test, knock set, filter)
// before out_valid, a failed test jumping ahead; no new request is taken while the sequencer is busy (in_stall)
// a channel at or above CHANNELS goes straight to the last step and gives result 0
// a result still waiting in the output register holds the last step for as long as it stalls
// reset (rst, synchronous) clears generator, per-channel flame/filter/wind and loads defaults
module candle_flicker_generator import cflk_pkg::*; #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CH_W-1:0]   channel,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] brightness,
  // configuration port
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // only channels the 3-bit field can name get storage
  localparam int unsigned DEPTH = (CHANNELS < 8) ? CHANNELS : 8;
  localparam int unsigned SEL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [7:0] gust_threshold;
  logic [6:0] approach_step;
  logic [2:0] calmness_shift;
  logic [7:0] wind_floor;

  // per-channel state, small enough for flops
  logic [DATA_W-1:0] flame_mem    [DEPTH];
  logic [DATA_W-1:0] filtered_mem [DEPTH];
  logic [DATA_W-1:0] wind_mem     [DEPTH];

  // working registers of the running request
  logic [SEL_W-1:0]  sel;
  logic              skip;
  logic [DATA_W-1:0] wind, flame, level;
  logic [DATA_W-1:0] level_next;

  logic              accept, in_range, cond, out_free, draw;
  logic [DATA_W-1:0] rnd, agility, calm_limit;
  ctrl_t             ctrl;
  logic              busy;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign in_range = {6'd0, channel} < 9'(CHANNELS);
  assign out_free = !out_valid || !out_stall;
  assign draw     = busy && ctrl.draw && !skip;

  assign agility    = {1'b0, approach_step};
  assign calm_limit = wind >> calmness_shift;

  cflk_rng u_rng (
    .clk   (clk),
    .rst   (rst),
    .draw  (draw),
    .value (rnd)
  );

  cflk_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .start_step (in_range ? S_GUST_TEST : S_FILTER),
    .cond       (cond),
    .out_free   (out_free),
    .ctrl       (ctrl),
    .busy       (busy)
  );

  // branch test on this step's draw
  always_comb begin
    unique case (ctrl.cmp)
      CMP_LT_VAR:   cond = rnd < gust_threshold;
      CMP_GT_LIMIT: cond = rnd > GUST_LIMIT;
      CMP_LT_CALM:  cond = rnd < calm_limit;
      default:      cond = 1'b1;
    endcase
  end

  // constant-rate approach; a flame equal to the level counts as not above
  always_comb begin
    level_next = level;
    if (flame > level) begin
      if (level < (LEVEL_MAX - agility)) begin
        level_next = level + agility;
      end
    end else if (level > agility) begin
      level_next = level - agility;
    end
  end

  // configuration writes, expected only while no request is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      gust_threshold <= RST_VARIABILITY;
      approach_step  <= RST_AGILITY;
      calmness_shift <= RST_CALMNESS;
      wind_floor     <= RST_BASELINE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VARIABILITY: gust_threshold <= cfg_data;
        REG_AGILITY:     approach_step  <= cfg_data[6:0];
        REG_CALMNESS:    calmness_shift <= cfg_data[2:0];
        REG_BASELINE:    wind_floor     <= cfg_data;
        default:         ;
      endcase
    end
  end

  // load the channel on accept, then let the program work on the copies
  always_ff @(posedge clk) begin
    if (accept) begin
      sel   <= channel[SEL_W-1:0];
      skip  <= !in_range;
      wind  <= wind_mem[channel[SEL_W-1:0]];
      flame <= flame_mem[channel[SEL_W-1:0]];
      level <= filtered_mem[channel[SEL_W-1:0]];
    end else if (busy) begin
      if (ctrl.load_wind) begin
        wind <= rnd;
      end
      if (ctrl.settle) begin
        if (wind > wind_floor) begin
          wind <= wind - 8'd1;
        end
        if (flame != LEVEL_MAX) begin
          flame <= flame + 8'd1;
        end
      end
      if (ctrl.load_flame) begin
        flame <= rnd;
      end
    end
  end

  // write back at the last step, once the output register can take the result
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        flame_mem[i]    <= '0;
        filtered_mem[i] <= '0;
        wind_mem[i]     <= '0;
      end
    end else if (busy && ctrl.fin && out_free && !skip) begin
      flame_mem[sel]    <= flame;
      filtered_mem[sel] <= level_next;
      wind_mem[sel]     <= wind;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (busy && ctrl.fin && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && ctrl.fin && out_free) begin
      brightness <= skip ? '0 : level_next;
    end
  end

`ifndef SYNTHESIS
  // a result only appears after the program reached its last step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy && ctrl.fin))
    else $error("result without a finished program");

  // an accepted request always starts the sequencer
  assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not start the program");

  // the last step holds while the output register is full
  assert property (@(posedge clk) disable iff (rst)
    busy && ctrl.fin && !out_free |=> busy && ctrl.fin)
    else $error("program left its last step with the output full");

  // an out-of-range channel never advances the generator
  assert property (@(posedge clk) disable iff (rst)
    busy && skip |-> !ctrl.draw)
    else $error("generator drawn for an out-of-range channel");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for candle_flicker_generator: directed plan, then random phases
// depends on cflk_pkg and the candle_flicker_generator rtl; reads no files
module tb;
  import cflk_pkg::*;

  localparam int N_CH      = 8;    // channels built into the instance
  localparam int IDLE_GAP  = 12;   // cycles after the last result before a register write
  localparam int IDLE_PCT  = 34;   // chance of an idle cycle on either side
  localparam int N_PHASES  = 6;

  // clock and synchronous reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // block ports, inputs all known from time zero
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [CH_W-1:0]   channel   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] brightness;
  logic              cfg_we    = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;

  candle_flicker_generator #(.CHANNELS(N_CH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .channel   (channel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .brightness(brightness),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // predictor: own copy of the shared generator, per-channel flame state and
  // the four settings, advanced once per accepted request
  // ---------------------------------------------------------------------------
  logic [7:0] gen_count = '0;
  logic [7:0] gen_a     = '0;
  logic [7:0] gen_b     = '0;
  logic [7:0] gen_c     = '0;
  logic [7:0] flame_q   [N_CH];
  logic [7:0] glow_q    [N_CH];
  logic [7:0] wind_q    [N_CH];

  logic [7:0] variability_q = RST_VARIABILITY;
  logic [6:0] agility_q     = RST_AGILITY;
  logic [2:0] calmness_q    = RST_CALMNESS;
  logic [7:0] baseline_q    = RST_BASELINE;

  initial begin
    for (int k = 0; k < N_CH; k++) begin
      flame_q[k] = '0;
      glow_q[k]  = '0;
      wind_q[k]  = '0;
    end
  end

  // one draw of the shared 8-bit generator, everything wraps at 8 bits
  function automatic logic [7:0] gen_draw();
    gen_count = gen_count + 8'd1;
    gen_a     = gen_a ^ gen_c ^ gen_count;
    gen_b     = gen_b + gen_a;
    gen_c     = (gen_c + (gen_b >> 1)) ^ gen_a;
    return gen_c;
  endfunction

  // one flame update of a channel, returns its new filtered brightness
  function automatic logic [7:0] next_brightness(input logic [CH_W-1:0] ch);
    logic [7:0] wind;
    logic [7:0] flame;
    logic [7:0] lvl;
    if (int'(ch) >= N_CH) return 8'd0;
    wind  = wind_q[ch];
    flame = flame_q[ch];
    lvl   = glow_q[ch];
    // rare gust: needs a low first draw and a high second one
    if (gen_draw() < variability_q) begin
      if (gen_draw() > GUST_LIMIT) wind = gen_draw();
    end
    // wind decays toward the baseline, flame creeps up
    if (wind > baseline_q) wind = wind - 8'd1;
    if (flame < LEVEL_MAX) flame = flame + 8'd1;
    // knock-down odds scale with the wind
    if (gen_draw() < (wind >> calmness_q)) flame = gen_draw();
    // constant-step approach, equal counts as not above so it steps down
    if (flame > lvl) begin
      if (int'(lvl) < 255 - int'(agility_q)) lvl = lvl + agility_q;
    end else if (lvl > agility_q) begin
      lvl = lvl - agility_q;
    end
    wind_q[ch]  = wind;
    flame_q[ch] = flame;
    glow_q[ch]  = lvl;
    return lvl;
  endfunction

  // ---------------------------------------------------------------------------
  // expected results and run bookkeeping
  // ---------------------------------------------------------------------------
  logic [7:0] brightness_due [$];
  logic [7:0] due_now;
  logic       steady = 1'b0;   // both sides run without idling
  int         n_requests = 0;
  int         n_checked  = 0;
  int         n_writes   = 0;
  int         n_errors   = 0;

  // result side: check against the oldest expectation, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (brightness_due.size() == 0) begin
        $error("brightness: no result expected, got %0d", brightness);
        n_errors++;
      end else begin
        due_now = brightness_due.pop_front();
        if (brightness !== due_now) begin
          $error("brightness: expected %0d, got %0d", due_now, brightness);
          n_errors++;
        end
        n_checked++;
      end
    end
    out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  // one request; a pinned request uses the typed value as its expectation
  task automatic push_request(input logic [CH_W-1:0] ch, input logic pinned,
                              input logic [7:0] want);
    logic [7:0] guess;
    while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    channel  <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    guess = next_brightness(ch);
    brightness_due.push_back(pinned ? want : guess);
    n_requests++;
  endtask

  // hold requests until every result is back, then let the pipe go quiet
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (brightness_due.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // register write, only called with the block idle
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_VARIABILITY: variability_q = d;
      REG_AGILITY:     agility_q     = d[6:0];
      REG_CALMNESS:    calmness_q    = d[2:0];
      REG_BASELINE:    baseline_q    = d;
      default: ;
    endcase
    n_writes++;
  endtask

  // setting for a random phase, extremes a good share of the time
  function automatic logic [CFG_W-1:0] pick_setting();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // directed plan: requests and register writes in order
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [CFG_W-1:0]  data;
    logic [CH_W-1:0]   ch;
    logic              pinned;
    logic [7:0]        want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic plan_row_t req_row(input logic [CH_W-1:0] ch);
    return '{kind: ROW_REQ, idx: '0, data: '0, ch: ch, pinned: 1'b0, want: '0};
  endfunction

  function automatic plan_row_t cfg_row(input logic [IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] d);
    return '{kind: ROW_CFG, idx: idx, data: d, ch: '0, pinned: 1'b0, want: '0};
  endfunction

  initial begin
    logic [CH_W-1:0] hot;
    logic [CH_W-1:0] ch;
    int              n_items;

    // defaults after reset: first update of channel 0 lifts it by the agility
    plan.push_back('{kind: ROW_REQ, idx: '0, data: '0, ch: 3'd0, pinned: 1'b1,
                     want: 8'd2});
    for (int k = 7; k >= 1; k--) plan.push_back(req_row(CH_W'(k)));
    // stormy: almost every first draw may gust, and any wind gives knock-down odds
    plan.push_back(cfg_row(REG_VARIABILITY, 8'hFF));
    plan.push_back(cfg_row(REG_CALMNESS, 8'h00));
    plan.push_back(cfg_row(REG_BASELINE, 8'h00));
    plan.push_back(cfg_row(REG_AGILITY, 8'd127));
    plan.push_back(req_row(3'd0));
    plan.push_back(req_row(3'd7));
    plan.push_back(req_row(3'd0));
    plan.push_back(req_row(3'd7));
    plan.push_back(req_row(3'd3));
    // zero step, the filtered level freezes
    plan.push_back(cfg_row(REG_AGILITY, 8'h00));
    plan.push_back(req_row(3'd5));
    plan.push_back(req_row(3'd2));
    // calm: no gusts, widest shift, top baseline; upper data bits get masked
    plan.push_back(cfg_row(REG_VARIABILITY, 8'h00));
    plan.push_back(cfg_row(REG_CALMNESS, 8'hFF));
    plan.push_back(cfg_row(REG_BASELINE, 8'hFF));
    plan.push_back(cfg_row(REG_AGILITY, 8'hFF));
    plan.push_back(req_row(3'd4));
    plan.push_back(req_row(3'd4));
    plan.push_back(req_row(3'd4));
    plan.push_back(req_row(3'd6));
    // middle of the road
    plan.push_back(cfg_row(REG_AGILITY, 8'd1));
    plan.push_back(cfg_row(REG_VARIABILITY, 8'd128));
    plan.push_back(cfg_row(REG_CALMNESS, 8'd3));
    plan.push_back(cfg_row(REG_BASELINE, 8'd30));
    plan.push_back(req_row(3'd1));
    plan.push_back(req_row(3'd1));
    plan.push_back(req_row(3'd6));
    plan.push_back(req_row(3'd0));
    plan.push_back(req_row(3'd7));
    plan.push_back(req_row(3'd2));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        push_request(plan[i].ch, plan[i].pinned, plan[i].want);
      end
    end

    // random phases; the first keeps one channel calm long enough for the
    // flame to reach the top and the filtered level to sit against it
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle_idle();
      if (ph == 0) begin
        write_reg(REG_VARIABILITY, 8'h00);
        write_reg(REG_CALMNESS, 8'hFF);
        write_reg(REG_BASELINE, 8'h00);
        write_reg(REG_AGILITY, pick_setting());
        n_items = 280;
      end else begin
        write_reg(REG_VARIABILITY, pick_setting());
        write_reg(REG_AGILITY, pick_setting());
        write_reg(REG_CALMNESS, pick_setting());
        write_reg(REG_BASELINE, pick_setting());
        n_items = 175;
      end
      hot    = CH_W'($urandom_range(0, N_CH - 1));
      steady = (ph == 2);
      for (int k = 0; k < n_items; k++) begin
        // once mid-phase: stop sending until the result side has caught up
        if (ph == 3 && k == 80) settle_idle();
        if (ph == 0 || $urandom_range(0, 1) == 0) ch = hot;
        else ch = CH_W'($urandom_range(0, N_CH - 1));
        push_request(ch, 1'b0, 8'd0);
      end
      steady = 1'b0;
    end

    settle_idle();
    repeat (IDLE_GAP) @(posedge clk);

    $display("ran %0d channel requests over %0d register writes and %0d settings phases",
             n_requests, n_writes, N_PHASES + 4);
    $display("%0d brightness results compared, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("[candle_flicker_generator] OK");
    end else begin
      $display("[candle_flicker_generator] ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #400000;
    $display("[candle_flicker_generator] ERROR");
    $finish;
  end

endmodule
